[design/crpr_pkg.sv]
// Shared constants, register codes and types of the character row pixel renderer
`default_nettype none

package crpr_pkg;

	// display geometry
	localparam int unsigned FIELD_PERIOD  = 560;
	localparam int unsigned GFX_THRESHOLD = 12;
	localparam int unsigned TEXT_PITCH    = 7;

	// widths of internal values
	localparam int unsigned XW    = 11;  // column times cell width, up to 2032
	localparam int unsigned CNT_W = 5;   // pixels per cell, 0..16

	// item kinds
	localparam logic KIND_CELL = 1'b0;
	localparam logic KIND_FONT = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CHAR_HEIGHT     = 2'd0,
		REG_COLUMNS_PER_ROW = 2'd1,
		REG_BITMAP_WIDTH    = 2'd2
	} cfg_reg_t;

	// one cell handed to the pixel serializer
	typedef struct packed {
		logic [15:0]      word;
		logic [XW-1:0]    base_x;
		logic [CNT_W-1:0] count;
		logic             inv;
		logic [8:0]       row_y;
	} crpr_load_t;

	// graphics cell width: 560 / columns, clamped to 16 (zero columns gives 16)
	function automatic logic [CNT_W-1:0] gfx_cell_width(input logic [7:0] cpr);
		logic [CNT_W-1:0] w;
		logic [12:0]      prod;
		w = '0;
		for (int k = 1; k <= 16; k++) begin
			prod = 13'(k) * {5'b0, cpr};
			if (prod <= 13'(FIELD_PERIOD)) begin
				w = w + 1'b1;
			end
		end
		return w;
	endfunction

endpackage

`default_nettype wire

[design/crpr_in_if.sv]
// Input channel: cell items and font write items
`default_nettype none

interface crpr_in_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [15:0]       cell_code;
	logic [3:0]        line_in_cell;
	logic [6:0]        column_index;
	logic signed [7:0] cursor_column;
	logic [8:0]        row_y;
	logic [13:0]       font_address;
	logic [15:0]       font_word;

	modport source (
		output valid, kind, cell_code, line_in_cell, column_index, cursor_column,
		output row_y, font_address, font_word,
		input  ready
	);

	modport sink (
		input  valid, kind, cell_code, line_in_cell, column_index, cursor_column,
		input  row_y, font_address, font_word,
		output ready
	);
endinterface

`default_nettype wire

[design/crpr_out_if.sv]
// Output channel: pixel items
`default_nettype none

interface crpr_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] pixel_x;
	logic [8:0] pixel_y;
	logic       lit;
	logic       last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, lit, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, lit, last_pixel,
		output ready
	);
endinterface

`default_nettype wire

[design/crpr_serializer.sv]
// Pixel serializer: shifts one cell's font word out as pixel items
`default_nettype none

module crpr_serializer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ld_valid,
	input  wire crpr_pkg::crpr_load_t ld,
	output logic                    ld_ready,
	crpr_out_if.source              pixels
);

	logic                         valid_q;
	logic [15:0]                  word_q;
	logic [crpr_pkg::XW-1:0]      x_q;
	logic [crpr_pkg::CNT_W-1:0]   left_q;
	logic                         inv_q;
	logic [8:0]                   y_q;
	logic                         out_acc;
	logic                         at_last;

	assign at_last  = (left_q == crpr_pkg::CNT_W'(1));
	assign out_acc  = valid_q && pixels.ready;
	assign ld_ready = !valid_q || (pixels.ready && at_last);

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld_valid && ld_ready) begin
			valid_q <= 1'b1;
		end else if (out_acc && at_last) begin
			valid_q <= 1'b0;
		end
	end

	// load a cell, then step one pixel per taken item
	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) begin
			word_q <= ld.word;
			x_q    <= ld.base_x;
			left_q <= ld.count;
			inv_q  <= ld.inv;
			y_q    <= ld.row_y;
		end else if (out_acc) begin
			word_q <= {word_q[14:0], 1'b0};
			x_q    <= x_q + 1'b1;
			left_q <= left_q - 1'b1;
		end
	end

	// pixel outputs straight from registers
	assign pixels.valid      = valid_q;
	assign pixels.pixel_x    = x_q[9:0];
	assign pixels.pixel_y    = y_q;
	assign pixels.lit        = word_q[15] ^ inv_q;
	assign pixels.last_pixel = at_last;

endmodule

`default_nettype wire

[design/char_row_pixel_renderer_top.sv]
// Character row pixel renderer: font store, cell lookup and pixel serializer
// Path: a cell item is registered in the lookup stage, then loaded into the serializer, whose
//   registers offer its first pixel item; a busy serializer holds the cell in the lookup stage.
// Throughput: one pixel item per cycle while the receiver is ready; a cell holds the serializer
//   until all its pixels (up to 16) are taken; blank or fully clipped cells and font writes never reach it.
// Reset: arst_n clears control and loads the register defaults; the font store is not cleared.
`default_nettype none

module char_row_pixel_renderer_top #(
	parameter int CODE_BITS = 10,
	parameter int LINE_BITS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	crpr_in_if.sink         cells,
	crpr_out_if.source      pixels,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [9:0] cfg_wdata
);

	localparam int ADDR_BITS = CODE_BITS + LINE_BITS;
	localparam int DEPTH     = 1 << ADDR_BITS;

	logic [4:0]                 rows_q;
	logic [crpr_pkg::CNT_W-1:0] cell_w_q;
	logic [9:0]                 bmp_w_q;
	logic                       gfx_mode;

	logic                       accept;
	logic                       font_wr;
	logic                       cell_acc;
	logic [ADDR_BITS-1:0]       wr_addr;
	logic [ADDR_BITS-1:0]       rd_addr;
	logic [LINE_BITS-1:0]       line_sel;
	logic [crpr_pkg::CNT_W-1:0] col_mul;
	logic [crpr_pkg::XW-1:0]    base_x;
	logic                       cursor_on;

	logic [15:0]                font_mem [DEPTH];
	logic [15:0]                rd_s1;
	logic                       valid_s1;
	logic [crpr_pkg::XW-1:0]    base_s1;
	logic                       inv_s1;
	logic [8:0]                 y_s1;

	logic                       low_ones;
	logic                       zero_found;
	logic [3:0]                 zero_pos;
	logic [crpr_pkg::CNT_W-1:0] text_w;
	logic [crpr_pkg::CNT_W-1:0] text_cnt;
	logic [crpr_pkg::XW-1:0]    room;
	logic [crpr_pkg::CNT_W-1:0] gfx_cnt;
	logic [crpr_pkg::CNT_W-1:0] count_s1;
	logic                       s1_adv;

	crpr_pkg::crpr_load_t       ld;
	logic                       ld_valid;
	logic                       ld_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= 5'd9;
			cell_w_q <= crpr_pkg::gfx_cell_width(8'd80);
			bmp_w_q  <= 10'd560;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crpr_pkg::REG_CHAR_HEIGHT:     rows_q   <= cfg_wdata[4:0];
				crpr_pkg::REG_COLUMNS_PER_ROW:
					cell_w_q <= crpr_pkg::gfx_cell_width(cfg_wdata[7:0]);
				crpr_pkg::REG_BITMAP_WIDTH:    bmp_w_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign gfx_mode = (rows_q >= 5'(crpr_pkg::GFX_THRESHOLD));

	// input handshake and address forming
	assign accept   = cells.valid && cells.ready;
	assign font_wr  = accept && (cells.kind == crpr_pkg::KIND_FONT);
	assign cell_acc = accept && (cells.kind == crpr_pkg::KIND_CELL);
	assign wr_addr  = ADDR_BITS'(cells.font_address);
	assign line_sel = LINE_BITS'(cells.line_in_cell);
	assign rd_addr  = {cells.cell_code[CODE_BITS-1:0], line_sel};

	// cell start position and cursor match
	assign col_mul   = gfx_mode ? cell_w_q : crpr_pkg::CNT_W'(crpr_pkg::TEXT_PITCH);
	assign base_x    = crpr_pkg::XW'(cells.column_index) * crpr_pkg::XW'(col_mul);
	assign cursor_on = !cells.cursor_column[7] &&
	                   (cells.cursor_column[6:0] == cells.column_index);

	// font store: write on a font item, registered read on a cell item
	always_ff @(posedge clk) begin
		if (font_wr) begin
			font_mem[wr_addr] <= cells.font_word;
		end
		if (cell_acc) begin
			rd_s1 <= font_mem[rd_addr];
		end
	end

	// lookup stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cells.ready) begin
			valid_s1 <= cell_acc;
		end
	end

	// lookup stage payload
	always_ff @(posedge clk) begin
		if (cell_acc) begin
			base_s1 <= base_x;
			inv_s1  <= cursor_on;
			y_s1    <= cells.row_y;
		end
	end

	// text width from the guard run: lowest zero among bits 8..14
	always_comb begin
		zero_found = 1'b0;
		zero_pos   = 4'd0;
		for (int i = 14; i >= 8; i--) begin
			if (!rd_s1[i]) begin
				zero_found = 1'b1;
				zero_pos   = 4'(i);
			end
		end
	end

	assign low_ones = &rd_s1[7:0];
	assign text_w   = (low_ones && zero_found) ?
	                  crpr_pkg::CNT_W'(5'd15 - {1'b0, zero_pos}) :
	                  crpr_pkg::CNT_W'(crpr_pkg::TEXT_PITCH);
	// blank cell without the cursor gives nothing
	assign text_cnt = ((rd_s1[7:0] == 8'h00) && !inv_s1) ? '0 : text_w;

	// graphics: clip the cell against the bitmap width
	assign room    = crpr_pkg::XW'(bmp_w_q) - base_s1;
	assign gfx_cnt = (base_s1 >= crpr_pkg::XW'(bmp_w_q)) ? '0 :
	                 (room < crpr_pkg::XW'(cell_w_q)) ? room[crpr_pkg::CNT_W-1:0] : cell_w_q;

	assign count_s1 = gfx_mode ? gfx_cnt : text_cnt;

	// hand off to the serializer, empty cells retire at once
	assign s1_adv      = valid_s1 && ((count_s1 == '0) || ld_ready);
	assign cells.ready = !valid_s1 || s1_adv;
	assign ld_valid    = valid_s1 && (count_s1 != '0);

	always_comb begin
		ld.word   = rd_s1;
		ld.base_x = base_s1;
		ld.count  = count_s1;
		ld.inv    = inv_s1;
		ld.row_y  = y_s1;
	end

	crpr_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (ld_valid),
		.ld       (ld),
		.ld_ready (ld_ready),
		.pixels   (pixels)
	);

endmodule

`default_nettype wire

[design/crpr_checker.sv]
// Port checker of the character row pixel renderer and its bind
`default_nettype none

module crpr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cells_ready,
	input wire logic       pixels_valid,
	input wire logic       pixels_ready,
	input wire logic [9:0] pixel_x,
	input wire logic [8:0] pixel_y,
	input wire logic       lit,
	input wire logic       last_pixel
);

	// a stalled pixel item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixels_valid && !pixels_ready |=> pixels_valid && $stable(pixel_x) &&
		$stable(pixel_y) && $stable(lit) && $stable(last_pixel))
		else $error("pixel item changed while stalled");

	// pixels of one cell follow without a gap, one position apart
	a_cell_run: assert property (@(posedge clk) disable iff (!arst_n)
		pixels_valid && pixels_ready && !last_pixel |=>
		pixels_valid && (pixel_x == $past(pixel_x) + 10'd1))
		else $error("cell pixels not contiguous");

	// one cell stays on one screen line
	a_cell_line: assert property (@(posedge clk) disable iff (!arst_n)
		pixels_valid && pixels_ready && !last_pixel |=> pixel_y == $past(pixel_y))
		else $error("screen line changed within a cell");

	// input backpressure only comes from a waiting pixel
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cells_ready |-> pixels_valid)
		else $error("input stalled with no pixel pending");

endmodule

bind char_row_pixel_renderer_top crpr_checker u_crpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cells_ready  (cells.ready),
	.pixels_valid (pixels.valid),
	.pixels_ready (pixels.ready),
	.pixel_x      (pixels.pixel_x),
	.pixel_y      (pixels.pixel_y),
	.lit          (pixels.lit),
	.last_pixel   (pixels.last_pixel)
);

`default_nettype wire

[sim/char_row_pixel_renderer_top_tb.sv]
// Testbench of the character row pixel renderer: random and directed items, pixel scoreboard
`timescale 1ns / 100ps

module char_row_pixel_renderer_top_tb;

	localparam int CODE_BITS   = 10;
	localparam int LINE_BITS   = 4;
	localparam int GLYPH_DEPTH = 1 << (CODE_BITS + LINE_BITS);
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 8;
	localparam int IDLE_PCT    = 38;
	localparam int BATCH       = 27;

	// one input item as driven on the cell channel
	typedef struct packed {
		logic              kind;
		logic [15:0]       cell_code;
		logic [3:0]        line_in_cell;
		logic [6:0]        column_index;
		logic signed [7:0] cursor_column;
		logic [8:0]        row_y;
		logic [13:0]       font_address;
		logic [15:0]       font_word;
	} cell_req_t;

	localparam int REQ_W = $bits(cell_req_t);

	// one pixel item
	typedef struct packed {
		logic [9:0] x;
		logic [8:0] y;
		logic       lit;
		logic       last;
	} pixel_t;

	// font store copy, register copy and the queue of pixels still to come
	class glyph_pixel_model;
		logic [15:0] glyphs [0:GLYPH_DEPTH-1];
		int unsigned char_lines      = 9;
		int unsigned columns_per_row = 80;
		int unsigned bitmap_width    = 560;
		pixel_t      expected_pixels [$];
		int          errors;

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("%0t ns  mismatch: %s", $time, msg);
		endtask

		function int pending();
			return expected_pixels.size();
		endfunction

		function void set_reg(crpr_pkg::cfg_reg_t idx, logic [9:0] v);
			case (idx)
				crpr_pkg::REG_CHAR_HEIGHT:     char_lines      = v[4:0];
				crpr_pkg::REG_COLUMNS_PER_ROW: columns_per_row = v[7:0];
				crpr_pkg::REG_BITMAP_WIDTH:    bitmap_width    = v[9:0];
				default: ;
			endcase
		endfunction

		// render one accepted item into expected pixels
		function void note_item(cell_req_t r);
			logic [15:0] w;
			logic [13:0] a;
			logic        hit;
			int          z;
			int          span;
			int          xpos;
			pixel_t      px;
			pixel_t      cell_px [$];
			if (r.kind == crpr_pkg::KIND_FONT) begin
				glyphs[r.font_address] = r.font_word;
				return;
			end
			// cursor only counts when non-negative and on this column
			hit = (r.cursor_column[7] == 1'b0) && (r.cursor_column[6:0] == r.column_index);
			a = {r.cell_code[CODE_BITS-1:0], r.line_in_cell[LINE_BITS-1:0]};
			w = glyphs[a];
			px.y = r.row_y;
			px.last = 1'b0;
			if (char_lines < crpr_pkg::GFX_THRESHOLD) begin
				// text layout: blank cells skipped, width from the guard run
				if (w[7:0] == 8'h00 && !hit)
					return;
				z = 0;
				while (z < 16 && w[z] == 1'b1)
					z++;
				span = (z >= 15 || z < 8) ? crpr_pkg::TEXT_PITCH : 15 - z;
				for (int p = 0; p < span; p++) begin
					px.x = 10'(int'(r.column_index) * crpr_pkg::TEXT_PITCH + p);
					px.lit = w[15-p] ^ hit;
					cell_px.push_back(px);
				end
			end else begin
				// graphics layout: fixed cell width, clip at bitmap width
				span = (columns_per_row == 0) ? 16 : crpr_pkg::FIELD_PERIOD / columns_per_row;
				if (span > 16)
					span = 16;
				for (int p = 0; p < span; p++) begin
					xpos = int'(r.column_index) * span + p;
					if (xpos < bitmap_width) begin
						px.x = 10'(xpos);
						px.lit = w[15-p] ^ hit;
						cell_px.push_back(px);
					end
				end
			end
			if (cell_px.size() > 0)
				cell_px[cell_px.size()-1].last = 1'b1;
			foreach (cell_px[i])
				expected_pixels.push_back(cell_px[i]);
		endfunction

		// compare one accepted pixel with the oldest expectation
		task check_pixel(pixel_t got);
			pixel_t exp_px;
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected pixel x=%0d y=%0d lit=%0b last=%0b",
					got.x, got.y, got.lit, got.last));
				return;
			end
			exp_px = expected_pixels.pop_front();
			if (got.x !== exp_px.x)
				report($sformatf("pixel_x got %0d want %0d", got.x, exp_px.x));
			if (got.y !== exp_px.y)
				report($sformatf("pixel_y got %0d want %0d (x=%0d)", got.y, exp_px.y, exp_px.x));
			if (got.lit !== exp_px.lit)
				report($sformatf("lit got %0b want %0b (x=%0d)", got.lit, exp_px.lit, exp_px.x));
			if (got.last !== exp_px.last)
				report($sformatf("last_pixel got %0b want %0b (x=%0d)",
					got.last, exp_px.last, exp_px.x));
		endtask
	endclass

	bit          clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_wdata;
	bit          calm;
	int          cycles;
	int          cur_rows;
	int          cur_cols;
	bit          font_known [0:GLYPH_DEPTH-1];
	logic [13:0] known_addrs [$];
	glyph_pixel_model sb;

	crpr_in_if  cells_if ();
	crpr_out_if pixels_if ();

	char_row_pixel_renderer_top #(
		.CODE_BITS(CODE_BITS),
		.LINE_BITS(LINE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cells    (cells_if),
		.pixels   (pixels_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		pixels_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// watch accepted items, pixels and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixels_if.valid && pixels_if.ready)
				sb.check_pixel({pixels_if.pixel_x, pixels_if.pixel_y,
					pixels_if.lit, pixels_if.last_pixel});
			if (cells_if.valid && cells_if.ready)
				sb.note_item({cells_if.kind, cells_if.cell_code, cells_if.line_in_cell,
					cells_if.column_index, cells_if.cursor_column, cells_if.row_y,
					cells_if.font_address, cells_if.font_word});
			if (cfg_we)
				sb.set_reg(crpr_pkg::cfg_reg_t'(cfg_index), cfg_wdata);
		end
	end

	// font write item; cell fields carry noise
	function automatic cell_req_t font_req(logic [13:0] addr, logic [15:0] word);
		cell_req_t   r;
		logic [95:0] noise;
		noise = {$urandom, $urandom, $urandom};
		r = cell_req_t'(noise[REQ_W-1:0]);
		r.kind = crpr_pkg::KIND_FONT;
		r.font_address = addr;
		r.font_word = word;
		if (!font_known[addr]) begin
			font_known[addr] = 1'b1;
			known_addrs.push_back(addr);
		end
		return r;
	endfunction

	// cell item reading a font entry that was written before
	function automatic cell_req_t cell_req(logic [13:0] addr, int col, int cur, int y);
		cell_req_t   r;
		logic [95:0] noise;
		noise = {$urandom, $urandom, $urandom};
		r = cell_req_t'(noise[REQ_W-1:0]);
		r.kind = crpr_pkg::KIND_CELL;
		r.cell_code = {6'($urandom), addr[13:4]};
		r.line_in_cell = addr[3:0];
		r.column_index = 7'(col);
		r.cursor_column = 8'(cur);
		r.row_y = 9'(y);
		return r;
	endfunction

	// word with a guard zero that sets the text width
	function automatic logic [15:0] guard_word(int width, logic [31:0] upper);
		int z;
		z = 15 - width;
		return 16'(upper << (z + 1)) | 16'((32'd1 << z) - 1);
	endfunction

	function automatic logic [15:0] pick_word();
		int sel;
		sel = $urandom_range(99);
		if (sel < 35)
			return 16'($urandom);
		else if (sel < 70)
			return guard_word($urandom_range(1, 7), $urandom);
		else if (sel < 85)
			return {8'($urandom), 8'h00};
		else if (sel < 92)
			return 16'hFFFF;
		else
			return 16'h7FFF;
	endfunction

	// offer one item, with random gaps ahead of it
	task automatic push_item(cell_req_t r);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			cells_if.valid <= 1'b0;
		end
		@(negedge clk);
		cells_if.valid         <= 1'b1;
		cells_if.kind          <= r.kind;
		cells_if.cell_code     <= r.cell_code;
		cells_if.line_in_cell  <= r.line_in_cell;
		cells_if.column_index  <= r.column_index;
		cells_if.cursor_column <= r.cursor_column;
		cells_if.row_y         <= r.row_y;
		cells_if.font_address  <= r.font_address;
		cells_if.font_word     <= r.font_word;
		do
			@(posedge clk);
		while (!cells_if.ready);
	endtask

	// drain the block, then write all three registers
	task automatic write_regs(int rows, int cols, int bw);
		@(negedge clk);
		cells_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= crpr_pkg::REG_CHAR_HEIGHT;
		cfg_wdata <= 10'(rows);
		@(negedge clk);
		cfg_index <= crpr_pkg::REG_COLUMNS_PER_ROW;
		cfg_wdata <= 10'(cols);
		@(negedge clk);
		cfg_index <= crpr_pkg::REG_BITMAP_WIDTH;
		cfg_wdata <= 10'(bw);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_rows = rows;
		cur_cols = cols;
	endtask

	// random mix of font writes and cells over known entries
	task automatic run_random(int n);
		logic [13:0] addr;
		int          col;
		int          cur;
		int          sel;
		for (int i = 0; i < n; i++) begin
			if (known_addrs.size() == 0 || $urandom_range(99) < 25) begin
				if ($urandom_range(1))
					addr = 14'($urandom);
				else
					addr = {5'd0, 9'($urandom)};
				push_item(font_req(addr, pick_word()));
			end else begin
				addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
				if (cur_rows >= crpr_pkg::GFX_THRESHOLD && $urandom_range(99) < 60)
					col = $urandom_range((cur_cols > 128 ? 128 : cur_cols) - 1);
				else
					col = $urandom_range(127);
				sel = $urandom_range(99);
				if (sel < 30)
					cur = col;
				else if (sel < 50)
					cur = -1;
				else
					cur = int'($urandom_range(128)) - 1;
				push_item(cell_req(addr, col, cur, $urandom_range(511)));
			end
		end
	endtask

	initial begin
		cells_if.valid         = 1'b0;
		cells_if.kind          = crpr_pkg::KIND_CELL;
		cells_if.cell_code     = '0;
		cells_if.line_in_cell  = '0;
		cells_if.column_index  = '0;
		cells_if.cursor_column = '0;
		cells_if.row_y         = '0;
		cells_if.font_address  = '0;
		cells_if.font_word     = '0;
		pixels_if.ready        = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = crpr_pkg::REG_CHAR_HEIGHT;
		cfg_wdata              = '0;
		arst_n                 = 1'b0;
		calm                   = 1'b0;
		cur_rows               = 9;
		cur_cols               = 80;
		sb = new;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values: text layout
		push_item(font_req(14'h0000, 16'hBFFF));  // width 1
		push_item(font_req(14'h3FFF, 16'hFEFF));  // width 7 by guard
		push_item(font_req(14'h1235, 16'hF7FF));  // width 4
		push_item(font_req(14'h2A5A, 16'hFFFF));  // no zero guard
		push_item(font_req(14'h0F0F, 16'h7FFF));  // guard at bit 15
		push_item(font_req(14'h00F1, 16'hA5F0));  // guard in low bits
		push_item(font_req(14'h3C03, 16'hFF00));  // blank low byte
		push_item(font_req(14'h1111, 16'h0000));  // all zero
		push_item(cell_req(14'h0000, 0, -1, 0));
		push_item(cell_req(14'h3FFF, 127, -1, 511));
		push_item(cell_req(14'h1235, 5, 5, 100));
		push_item(cell_req(14'h2A5A, 64, 63, 200));
		push_item(cell_req(14'h0F0F, 10, 127, 300));
		push_item(cell_req(14'h00F1, 127, 127, 5));
		push_item(cell_req(14'h3C03, 3, 2, 17));    // blank, skipped
		push_item(cell_req(14'h3C03, 3, 3, 18));    // blank under cursor
		push_item(cell_req(14'h1111, 0, 0, 19));
		push_item(cell_req(14'h1111, 40, -1, 20));  // skipped
		push_item(font_req(14'h0000, 16'hEFFF));    // overwrite, width 3
		push_item(cell_req(14'h0000, 1, -1, 21));
		run_random(BATCH);

		// no idling on either side here
		calm = 1'b1;
		write_regs(0, 35, 1);
		run_random(BATCH);
		calm = 1'b0;

		write_regs(12, 35, 1023);
		run_random(BATCH);
		write_regs(31, 128, 1);
		run_random(BATCH);
		write_regs(11, 128, 560);
		run_random(BATCH);
		write_regs(13, 80, 560);
		run_random(BATCH);
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 0)
				write_regs($urandom_range(12, 31), $urandom_range(35, 128),
					$urandom_range(1, 1023));
			else
				write_regs($urandom_range(31), $urandom_range(35, 128),
					$urandom_range(1, 1023));
			run_random(BATCH);
		end

		// drain and let stray pixels show up
		@(negedge clk);
		cells_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
design/crpr_pkg.sv
design/crpr_in_if.sv
design/crpr_out_if.sv
design/crpr_serializer.sv
design/char_row_pixel_renderer_top.sv
design/crpr_checker.sv
sim/char_row_pixel_renderer_top_tb.sv
